@@ rtl/wis_pkg.sv @@
// ----------------------------------------------------------------------------
// wis_pkg
// Types, operation codes and helpers shared by the weighted interval
// scheduling controller, datapath and top level.
// ----------------------------------------------------------------------------
package wis_pkg;

    localparam int TIME_W  = 20;
    localparam int KEY_W   = 21;
    localparam int WORTH_W = 30;
    localparam logic [WORTH_W-1:0] WORTH_MAX = {WORTH_W{1'b1}};

    // One stored event: a check when start equals end, an order otherwise.
    typedef struct packed {
        logic [KEY_W-1:0]   ev_start;
        logic [KEY_W-1:0]   ev_end;
        logic [WORTH_W-1:0] ev_worth;
    } event_t;

    // Operations the controller asks of the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INS_RD,
        OP_INS_CMP,
        OP_SW_INIT,
        OP_SW_RD,
        OP_SW_CMP,
        OP_BS_RD,
        OP_BS_CMP,
        OP_FINISH
    } op_t;

    // Status the datapath reports back to the controller.
    typedef struct packed {
        logic fits;
        logic last_flag;
        logic j_zero;
        logic key_gt;
        logic sel_done;
        logic i_end;
        logic check_ev;
        logic bs_empty;
        logic bs_eq;
    } status_t;

    // True when key (s1, e1) orders after key (s2, e2).
    function automatic logic key_after(input logic [KEY_W-1:0] s1,
                                       input logic [KEY_W-1:0] e1,
                                       input logic [KEY_W-1:0] s2,
                                       input logic [KEY_W-1:0] e2);
        return (s1 > s2) || ((s1 == s2) && (e1 > e2));
    endfunction

endpackage

@@ rtl/wis_ram.sv @@
// ----------------------------------------------------------------------------
// wis_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module wis_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 3072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/wis_ctrl.sv @@
// ----------------------------------------------------------------------------
// wis_ctrl
// Sequencer for loading, insertion into sorted order and the sweep with its
// binary searches.
// ----------------------------------------------------------------------------
module wis_ctrl
    import wis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    last,
    input  status_t status,
    output op_t     op,
    output logic    busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SW_INIT,
        ST_SW_RD,
        ST_SW_CMP,
        ST_BS_RD,
        ST_BS_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // Next state and the operation issued in the current state.
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op = OP_ACCEPT;
                    if (status.fits)
                    begin
                        state_next = ST_INS_RD;
                    end
                    else if (last)
                    begin
                        state_next = ST_SW_INIT;
                    end
                end
            end
            ST_INS_RD:
            begin
                op = OP_INS_RD;
                if (!status.j_zero)
                begin
                    state_next = ST_INS_CMP;
                end
                else if (status.sel_done)
                begin
                    state_next = status.last_flag ? ST_SW_INIT : ST_IDLE;
                end
            end
            ST_INS_CMP:
            begin
                op = OP_INS_CMP;
                if (status.key_gt || !status.sel_done)
                begin
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = status.last_flag ? ST_SW_INIT : ST_IDLE;
                end
            end
            ST_SW_INIT:
            begin
                op         = OP_SW_INIT;
                state_next = ST_SW_RD;
            end
            ST_SW_RD:
            begin
                op         = OP_SW_RD;
                state_next = status.i_end ? ST_FINISH : ST_SW_CMP;
            end
            ST_SW_CMP:
            begin
                op         = OP_SW_CMP;
                state_next = status.check_ev ? ST_SW_RD : ST_BS_RD;
            end
            ST_BS_RD:
            begin
                op         = OP_BS_RD;
                state_next = status.bs_empty ? ST_SW_RD : ST_BS_CMP;
            end
            ST_BS_CMP:
            begin
                op         = OP_BS_CMP;
                state_next = status.bs_eq ? ST_SW_RD : ST_BS_RD;
            end
            ST_FINISH:
            begin
                op         = OP_FINISH;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/wis_datapath.sv @@
// ----------------------------------------------------------------------------
// wis_datapath
// Event store, insertion shifter, sweep registers and binary search.
// ----------------------------------------------------------------------------
module wis_datapath
    import wis_pkg::*;
#(
    parameter int MAX_ORDERS = 1024,
    parameter int MAX_EVENTS = 3072
) (
    input  logic                clk,
    input  logic                rst_n,
    input  op_t                 op,
    input  logic [TIME_W-1:0]   order_start,
    input  logic [TIME_W-1:0]   duration,
    input  logic [TIME_W-1:0]   order_value,
    input  logic                last,
    output status_t             status,
    output logic                done,
    output logic [WORTH_W-1:0]  best_total
);

    localparam int AW  = $clog2(MAX_EVENTS);
    localparam int CW  = $clog2(MAX_EVENTS + 1);
    localparam int CAP = (MAX_EVENTS < 3 * MAX_ORDERS) ? MAX_EVENTS : 3 * MAX_ORDERS;
    localparam logic [CW:0] CAP_C = (CW + 1)'(CAP);

    // Control registers.
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [1:0]         sel_reg, sel_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [WORTH_W-1:0] best_reg, best_next;
    logic               done_reg, done_next;
    logic               last_reg, last_next;

    // Payload registers.
    logic [TIME_W-1:0]  s_reg, s_next;
    logic [TIME_W-1:0]  d_reg, d_next;
    logic [TIME_W-1:0]  v_reg, v_next;
    logic [KEY_W-1:0]   cur_end_reg, cur_end_next;
    logic [WORTH_W-1:0] cur_worth_reg, cur_worth_next;
    logic [WORTH_W-1:0] result_reg, result_next;

    // Memory port.
    logic               we;
    logic [AW-1:0]      waddr;
    event_t             wdata;
    logic [AW-1:0]      raddr;
    event_t             rdata;

    event_t             new_ev;
    logic [KEY_W-1:0]   s_ext;
    logic [KEY_W-1:0]   e_ext;
    logic [CW-1:0]      mid_calc;
    logic [WORTH_W:0]   sum_wide;
    logic [WORTH_W-1:0] sum_sat;
    logic               bs_lt;

    wis_ram #(
        .WIDTH ($bits(event_t)),
        .DEPTH (MAX_EVENTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The event being inserted: start check, order, or end check.
    assign s_ext = {1'b0, s_reg};
    assign e_ext = s_ext + {1'b0, d_reg};
    always_comb
    begin
        case (sel_reg)
            2'd0:    new_ev = '{ev_start: s_ext, ev_end: s_ext, ev_worth: '0};
            2'd1:    new_ev = '{ev_start: s_ext, ev_end: e_ext,
                                ev_worth: WORTH_W'(v_reg)};
            default: new_ev = '{ev_start: e_ext, ev_end: e_ext, ev_worth: '0};
        endcase
    end

    // Search midpoint and saturating sum.
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sum_wide = {1'b0, best_reg} + {1'b0, cur_worth_reg};
    assign sum_sat  = sum_wide[WORTH_W] ? WORTH_MAX : sum_wide[WORTH_W-1:0];
    assign bs_lt    = key_after(cur_end_reg, cur_end_reg, rdata.ev_start, rdata.ev_end);

    // Status toward the controller.
    always_comb
    begin
        status.fits      = ({1'b0, count_reg} + (CW + 1)'(3)) <= CAP_C;
        status.last_flag = last_reg;
        status.j_zero    = (j_reg == '0);
        status.key_gt    = key_after(rdata.ev_start, rdata.ev_end,
                                     new_ev.ev_start, new_ev.ev_end);
        status.sel_done  = (sel_reg == 2'd2);
        status.i_end     = (i_reg == count_reg);
        status.check_ev  = (rdata.ev_start == rdata.ev_end);
        status.bs_empty  = (lo_reg >= hi_reg);
        status.bs_eq     = (rdata.ev_start == cur_end_reg) && (rdata.ev_end == cur_end_reg);
    end

    // Operation decode.
    always_comb
    begin
        count_next     = count_reg;
        j_next         = j_reg;
        sel_next       = sel_reg;
        i_next         = i_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        best_next      = best_reg;
        done_next      = 1'b0;
        last_next      = last_reg;
        s_next         = s_reg;
        d_next         = d_reg;
        v_next         = v_reg;
        cur_end_next   = cur_end_reg;
        cur_worth_next = cur_worth_reg;
        result_next    = result_reg;
        we             = 1'b0;
        waddr          = j_reg[AW-1:0];
        wdata          = new_ev;
        raddr          = i_reg[AW-1:0];
        case (op)
            OP_ACCEPT:
            begin
                s_next    = order_start;
                d_next    = (duration == '0) ? TIME_W'(1) : duration;
                v_next    = order_value;
                last_next = last;
                sel_next  = 2'd0;
                j_next    = count_reg;
            end
            OP_INS_RD:
            begin
                raddr = AW'(j_reg - CW'(1));
                if (j_reg == '0)
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                    j_next     = count_reg + CW'(1);
                    sel_next   = sel_reg + 2'd1;
                end
            end
            OP_INS_CMP:
            begin
                we = 1'b1;
                if (status.key_gt)
                begin
                    // Shift the larger event up one place.
                    wdata  = rdata;
                    j_next = j_reg - CW'(1);
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    j_next     = count_reg + CW'(1);
                    sel_next   = sel_reg + 2'd1;
                end
            end
            OP_SW_INIT:
            begin
                i_next    = '0;
                best_next = '0;
            end
            OP_SW_RD:
            begin
                raddr = i_reg[AW-1:0];
            end
            OP_SW_CMP:
            begin
                cur_end_next   = rdata.ev_end;
                cur_worth_next = rdata.ev_worth;
                if (status.check_ev)
                begin
                    if (rdata.ev_worth > best_reg)
                    begin
                        best_next = rdata.ev_worth;
                    end
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    lo_next = '0;
                    hi_next = count_reg;
                end
            end
            OP_BS_RD:
            begin
                raddr    = mid_calc[AW-1:0];
                mid_next = mid_calc;
                if (lo_reg >= hi_reg)
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            OP_BS_CMP:
            begin
                if (status.bs_eq)
                begin
                    i_next = i_reg + CW'(1);
                    if (sum_sat > rdata.ev_worth)
                    begin
                        we    = 1'b1;
                        waddr = mid_reg[AW-1:0];
                        wdata = '{ev_start: rdata.ev_start, ev_end: rdata.ev_end,
                                  ev_worth: sum_sat};
                    end
                end
                else if (bs_lt)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            OP_FINISH:
            begin
                done_next   = 1'b1;
                result_next = best_reg;
                count_next  = '0;
                best_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            j_reg     <= '0;
            sel_reg   <= 2'd0;
            i_reg     <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
            best_reg  <= '0;
            done_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            j_reg     <= j_next;
            sel_reg   <= sel_next;
            i_reg     <= i_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            best_reg  <= best_next;
            done_reg  <= done_next;
            last_reg  <= last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        d_reg         <= d_next;
        v_reg         <= v_next;
        cur_end_reg   <= cur_end_next;
        cur_worth_reg <= cur_worth_next;
        result_reg    <= result_next;
    end

    assign done       = done_reg;
    assign best_total = result_reg;

endmodule

@@ rtl/weighted_interval_schedule.sv @@
// ----------------------------------------------------------------------------
// weighted_interval_schedule
// Best total value of non-overlapping orders, found by sorted event sweep.
// ----------------------------------------------------------------------------
// An order is taken when start is high and busy is low. Each order that
// fits in the store is stored as three events, and each event is inserted
// into sorted order as it arrives: every stored event with a larger key is
// shifted up one place, and each shift is a read and a write of the single
// event memory. After the order marked last, the sweep starts, reads each
// event in turn and, for each order event, runs a binary search of about
// log2 of the event count steps, then finishes.
// The result appears on best_total with done high for exactly one cycle,
// the cycle in which busy falls; the receiver cannot stall it, so it must be
// captured in that cycle. No result is produced for orders that are not
// marked last. The event memory needs no clearing.
// ----------------------------------------------------------------------------
module weighted_interval_schedule
    import wis_pkg::*;
#(
    parameter int MAX_ORDERS = 1024,
    parameter int MAX_EVENTS = 3072
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [TIME_W-1:0]  order_start,
    input  logic [TIME_W-1:0]  duration,
    input  logic [TIME_W-1:0]  order_value,
    input  logic               last,
    output logic               done,
    output logic [WORTH_W-1:0] best_total
);

    op_t     op;
    status_t status;

    wis_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    wis_datapath #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_EVENTS (MAX_EVENTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .order_start (order_start),
        .duration    (duration),
        .order_value (order_value),
        .last        (last),
        .status      (status),
        .done        (done),
        .best_total  (best_total)
    );

endmodule
